// File: rtl/psq_pkg.sv
package psq_pkg;

  // Control bytes of the SEQ stream
  localparam logic [7:0] BYTE_CLEAR     = 8'h93;
  localparam logic [7:0] BYTE_LOWER     = 8'h0e;
  localparam logic [7:0] BYTE_UPPER     = 8'h8e;
  localparam logic [7:0] BYTE_RVS_ON    = 8'h12;
  localparam logic [7:0] BYTE_RVS_OFF   = 8'h92;
  localparam logic [7:0] BYTE_CR_PLAIN  = 8'h0d;
  localparam logic [7:0] BYTE_CR_SHIFT  = 8'h8d;

  // Most bytes one cell can cause
  localparam int unsigned MAX_BYTES = 6;
  localparam int unsigned CNT_W     = 3;

  // Configuration register indexes
  localparam logic [1:0] REG_CHARSET = 2'd0;
  localparam logic [1:0] REG_WIDTH   = 2'd1;
  localparam logic [1:0] REG_HEIGHT  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] WIDTH_RST  = 8'd40;
  localparam logic [7:0] HEIGHT_RST = 8'd25;

  // Byte run caused by one cell
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      done;
  } run_t;

  // C64 colour index to color control byte
  function automatic logic [7:0] color_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h90;
      4'd1:    b = 8'h05;
      4'd2:    b = 8'h1c;
      4'd3:    b = 8'h9f;
      4'd4:    b = 8'h9c;
      4'd5:    b = 8'h1e;
      4'd6:    b = 8'h1f;
      4'd7:    b = 8'h9e;
      4'd8:    b = 8'h81;
      4'd9:    b = 8'h95;
      4'd10:   b = 8'h96;
      4'd11:   b = 8'h97;
      4'd12:   b = 8'h98;
      4'd13:   b = 8'h99;
      4'd14:   b = 8'h9a;
      4'd15:   b = 8'h9b;
      default: b = 8'h90;
    endcase
    return b;
  endfunction

  // 7-bit screen code to PETSCII
  function automatic logic [7:0] to_petscii(input logic [6:0] c);
    logic [7:0] cx;
    logic [7:0] r;
    cx = {1'b0, c};
    if (cx <= 8'h1f)       r = cx + 8'h40;
    else if (cx <= 8'h3f)  r = cx;
    else if (cx <= 8'h5d)  r = cx + 8'h80;
    else if (cx == 8'h5e)  r = 8'hff;
    else if (cx == 8'h5f)  r = 8'hdf;
    else                   r = cx + 8'h40;
    return r;
  endfunction

endpackage

// File: rtl/psq_encode.sv
module psq_encode import psq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [3:0] cell_color,
  input  logic [7:0] char_code,
  input  logic       charset_lower,
  input  logic [7:0] screen_width,
  input  logic [7:0] screen_height,
  output run_t       run
);

  logic [3:0] cur_color_r, cur_color_nxt;
  logic       color_known_r, color_known_nxt;
  logic       rvs_r, rvs_nxt;
  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;

  logic [8:0] width9, height9;
  logic       first_cell, color_emit, row_end, last_row, done, cr_emit;
  logic [CNT_W-1:0] n;

  // Byte run and next state for the presented cell
  always_comb begin
    width9     = (screen_width == 8'd0) ? 9'd256 : {1'b0, screen_width};
    height9    = (screen_height == 8'd0) ? 9'd256 : {1'b0, screen_height};
    first_cell = (col_r == 8'd0) && (row_r == 8'd0);
    color_emit = !color_known_r || (cell_color != cur_color_r);
    row_end    = ({1'b0, col_r} + 9'd1) >= width9;
    last_row   = ({1'b0, row_r} + 9'd1) >= height9;
    done       = row_end && last_row;
    cr_emit    = row_end && !last_row;

    run.bytes = '0;
    n = '0;
    if (first_cell) begin
      run.bytes[n] = BYTE_CLEAR;
      n = n + 1'b1;
      run.bytes[n] = charset_lower ? BYTE_LOWER : BYTE_UPPER;
      n = n + 1'b1;
    end
    if (color_emit) begin
      run.bytes[n] = color_byte(cell_color);
      n = n + 1'b1;
    end
    if (char_code[7] && !rvs_r) begin
      run.bytes[n] = BYTE_RVS_ON;
      n = n + 1'b1;
    end else if (!char_code[7] && rvs_r) begin
      run.bytes[n] = BYTE_RVS_OFF;
      n = n + 1'b1;
    end
    run.bytes[n] = to_petscii(char_code[6:0]);
    n = n + 1'b1;
    if (cr_emit) begin
      run.bytes[n] = char_code[7] ? BYTE_CR_PLAIN : BYTE_CR_SHIFT;
      n = n + 1'b1;
    end
    run.cnt  = n;
    run.done = done;

    // State update
    if (done) begin
      cur_color_nxt   = '0;
      color_known_nxt = 1'b0;
      rvs_nxt         = 1'b0;
      col_nxt         = '0;
      row_nxt         = '0;
    end else begin
      cur_color_nxt   = cell_color;
      color_known_nxt = 1'b1;
      rvs_nxt         = cr_emit ? 1'b0 : char_code[7];
      col_nxt         = row_end ? 8'd0 : col_r + 8'd1;
      row_nxt         = row_end ? row_r + 8'd1 : row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_color_r   <= '0;
      color_known_r <= 1'b0;
      rvs_r         <= 1'b0;
      col_r         <= '0;
      row_r         <= '0;
    end else if (accept) begin
      cur_color_r   <= cur_color_nxt;
      color_known_r <= color_known_nxt;
      rvs_r         <= rvs_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
    end
  end

endmodule

// File: rtl/psq_serial.sv
module psq_serial import psq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  run_t       run,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_seq_byte,
  output logic       out_last_of_run,
  output logic       out_screen_done
);

  run_t             run_r;
  logic [CNT_W-1:0] ptr_r;
  logic             valid_r;
  logic             last;

  // Present the byte under the pointer
  always_comb begin
    last            = (ptr_r == run_r.cnt - 1'b1);
    out_valid       = valid_r;
    out_seq_byte    = run_r.bytes[ptr_r];
    out_last_of_run = last;
    out_screen_done = last && run_r.done;
    free            = !valid_r || (out_ready && last);
  end

  // Run buffer: loads when empty or in the cycle its last byte leaves
  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ptr_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      ptr_r   <= '0;
    end else if (valid_r && out_ready) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        ptr_r <= ptr_r + 1'b1;
      end
    end
  end

endmodule

// File: rtl/petscii_screen_to_seq_stream_core.sv
// PETSCII screen to SEQ stream encoder.
// Input channel (in_valid/in_ready): one screen cell per transaction, in
// row-major order, carrying its color index and screen code.
// Output channel (out_valid/out_ready): one SEQ byte per transaction, with
// out_last_of_run on the final byte of a cell and out_screen_done on the
// final byte of the screen.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 charset,
// 1 screen width, 2 screen height (0 means 256 for either). Write only while idle.
// Latency: a cell's first byte appears the cycle after it is accepted.
// Throughput: one byte per cycle while out_ready is high; a cell causes
// 1 to 6 bytes (typically 1 to 3), and the single run buffer in front of
// the output sets this rate. The next cell is accepted in the cycle the
// previous cell's last byte is taken.
// Reset: the encoder state returns to the start of a screen and the config
// registers take their defaults (upper charset, 40 x 25).
// When the receiver stalls, the current byte holds and in_ready drops once
// the run buffer is full.
module petscii_screen_to_seq_stream_core import psq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_cell_color,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_seq_byte,
  output logic       out_last_of_run,
  output logic       out_screen_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic       charset_r;
  logic [7:0] width_r;
  logic [7:0] height_r;
  logic       accept;
  logic       free;
  run_t       run;

  assign cfg_ready = 1'b1;
  assign in_ready  = free;
  assign accept    = in_valid && free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charset_r <= 1'b0;
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHARSET: charset_r <= cfg_data[0];
        REG_WIDTH:   width_r   <= cfg_data;
        REG_HEIGHT:  height_r  <= cfg_data;
        default:     ;
      endcase
    end
  end

  psq_encode u_encode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .cell_color    (in_cell_color),
    .char_code     (in_char_code),
    .charset_lower (charset_r),
    .screen_width  (width_r),
    .screen_height (height_r),
    .run           (run)
  );

  psq_serial u_serial (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (accept),
    .run             (run),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seq_byte    (out_seq_byte),
    .out_last_of_run (out_last_of_run),
    .out_screen_done (out_screen_done)
  );

endmodule
